[design/timed_peer_blocklist_table_unit_defines.svh]
// Assertion macros for the timed peer blocklist table.
// Used by the top level only; no other dependencies.
`ifndef TIMED_PEER_BLOCKLIST_TABLE_UNIT_DEFINES_SVH
`define TIMED_PEER_BLOCKLIST_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TPBT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TPBT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TPBT_ASSERT(label, prop)
`define TPBT_NEVER(label, cond)
`endif
`endif

[design/tpbt_pkg.sv]
// Shared types and constants for the timed peer blocklist table.
// No dependencies.
package tpbt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [31:0] BLOCK_30_MS   = 32'd1800000;
    localparam logic [31:0] BLOCK_45_MS   = 32'd2700000;
    localparam logic [31:0] BLOCK_60_MS   = 32'd3600000;
    localparam logic [31:0] SWEEP_PERIOD  = 32'd3600000;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_ADD   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] user_id;
        logic [15:0] user_port;
        logic [15:0] kad_port;
        logic [31:0] server_address;
        logic        firewalled;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       is_dead;
        logic       table_full;
        logic [6:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic        mode;
        logic        low_id;
        logic [31:0] user_id;
        logic [15:0] user_port;
        logic [15:0] kad_port;
        logic [31:0] server_address;
        logic [31:0] now_ms;
        logic [31:0] expiry;
    } cmd_t;

    typedef struct packed {
        logic [31:0] peer_id;
        logic [15:0] user_port;
        logic [15:0] kad_port;
        logic [31:0] server_address;
        logic [31:0] expiry;
    } slot_t;

    typedef struct packed {
        logic busy;
        logic overflow;
    } bk_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_ACT,
        BK_SWEEP
    } bk_state_t;

endpackage

[design/tpbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/tpbt_front.sv]
// Front end: accepts items, classifies them and queues commands (two deep).
// Depends on tpbt_pkg.
module tpbt_front
    import tpbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     global_list,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       cls;
    logic [31:0] block_ms;

    // Pick the block time from the firewalled flag and the global list setting.
    always_comb
    begin
        if (item.firewalled)
        begin
            block_ms = global_list ? BLOCK_45_MS : BLOCK_60_MS;
        end
        else
        begin
            block_ms = global_list ? BLOCK_30_MS : BLOCK_45_MS;
        end
        cls.mode           = item.mode;
        cls.low_id         = (item.user_id[31:24] == 8'd0);
        cls.user_id        = item.user_id;
        cls.user_port      = item.user_port;
        cls.kad_port       = item.kad_port;
        cls.server_address = item.server_address;
        cls.now_ms         = item.now_ms;
        cls.expiry         = item.now_ms + block_ms;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

[design/tpbt_back.sv]
// Back end: scans the slot table for each command, updates it and sweeps.
// Depends on tpbt_pkg and tpbt_ram.
module tpbt_back
    import tpbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       res_space,
    output logic       res_push,
    output out_item_t  res,
    output bk_status_t status
);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = AW + 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_DEPTH);
    localparam logic [CW-1:0]    FULL_COUNT = CW'(TABLE_DEPTH);

    bk_state_t            state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 hit_reg, hit_next;
    logic [AW-1:0]        hit_idx_reg, hit_idx_next;
    logic [31:0]          hit_exp_reg, hit_exp_next;
    logic                 free_ok_reg, free_ok_next;
    logic [AW-1:0]        free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [31:0]          last_sweep_reg, last_sweep_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    slot_t                ram_wdata;
    logic [AW-1:0]        ram_raddr;
    slot_t                rd;
    logic [AW-1:0]        ci;
    logic                 have_data;
    logic                 slot_hit;
    logic                 sweep_due;

    tpbt_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    // Read data arrives in the cycle after its read address.
    assign ram_raddr = (cnt_reg == LAST) ? '0 : cnt_reg[AW-1:0];
    assign ci        = cnt_reg[AW-1:0] - AW'(1);
    assign have_data = (cnt_reg != '0);
    assign slot_hit  = valid_reg[ci] && (rd.peer_id == cmd_reg.user_id)
                       && ((rd.user_port == cmd_reg.user_port)
                           || (rd.kad_port == cmd_reg.kad_port))
                       && (!cmd_reg.low_id || (rd.server_address == cmd_reg.server_address));
    assign sweep_due = ((cmd_reg.now_ms - last_sweep_reg) > SWEEP_PERIOD);

    assign status.busy     = (state_reg != BK_IDLE);
    assign status.overflow = (count_reg > FULL_COUNT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && res_space)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (have_data && (slot_hit || cnt_reg == LAST))
                begin
                    state_next = BK_ACT;
                end
            end
            BK_ACT:
            begin
                if (cmd_reg.mode == MODE_ADD && !hit_reg && free_ok_reg && sweep_due)
                begin
                    state_next = BK_SWEEP;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SWEEP:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_exp_next    = hit_exp_reg;
        free_ok_next    = free_ok_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        last_sweep_next = last_sweep_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata.peer_id        = cmd_reg.user_id;
        ram_wdata.user_port      = cmd_reg.user_port;
        ram_wdata.kad_port       = cmd_reg.kad_port;
        ram_wdata.server_address = cmd_reg.server_address;
        ram_wdata.expiry         = cmd_reg.expiry;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && res_space)
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    cnt_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                end
            end
            BK_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (have_data)
                begin
                    if (slot_hit)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = ci;
                        hit_exp_next = rd.expiry;
                    end
                    else if (!valid_reg[ci] && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = ci;
                    end
                end
            end
            BK_ACT:
            begin
                cnt_next = '0;
                res_push = 1'b1;
                if (cmd_reg.mode == MODE_QUERY)
                begin
                    if (hit_reg)
                    begin
                        if (hit_exp_reg > cmd_reg.now_ms)
                        begin
                            res.is_dead = 1'b1;
                        end
                        else
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                else if (hit_reg)
                begin
                    ram_we = 1'b1;
                end
                else if (free_ok_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (sweep_due)
                    begin
                        res_push        = 1'b0;
                        last_sweep_next = cmd_reg.now_ms;
                    end
                end
                else
                begin
                    res.table_full = 1'b1;
                end
                res.entry_count = 7'(count_next);
            end
            BK_SWEEP:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (have_data && valid_reg[ci] && (rd.expiry < cmd_reg.now_ms))
                begin
                    valid_next[ci] = 1'b0;
                    count_next = count_reg - CW'(1);
                end
                if (cnt_reg == LAST)
                begin
                    res_push = 1'b1;
                    res.entry_count = 7'(count_next);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        hit_idx_reg  <= hit_idx_next;
        hit_exp_reg  <= hit_exp_next;
        free_idx_reg <= free_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            free_ok_reg    <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            last_sweep_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hit_reg        <= hit_next;
            free_ok_reg    <= free_ok_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            last_sweep_reg <= last_sweep_next;
        end
    end
endmodule

[design/timed_peer_blocklist_table_unit.sv]
// Timed peer blocklist table, top level: register port, front, back, result queue.
// Depends on tpbt_pkg, tpbt_front, tpbt_back and the defines header.
//
// Usage: requests enter through a queue-style port (push/full, payload item).
// Mode 0 asks whether a peer is blocked; mode 1 adds or refreshes a peer.
// Each request gives one transfer on the result queue (empty/pop, payload
// result): is_dead, table_full and the number of valid entries afterwards.
// The global_list register (APB, byte address 0) picks the block times.
//
// Rate: the back end walks the slot RAM one slot per cycle, so a request
// may walk the whole table before its result enters the result queue; a
// match ends the walk early. The back end takes a new request only once it
// is done with the last. An insert that triggers the hourly sweep walks the
// RAM once more. The single RAM read port sets this pace.
// The front queue holds two requests, so the sender can push while the back
// end works. Results wait in a two-entry queue; when the receiver stalls and
// that queue has no room, the back end holds the next request in the front.
// Reset empties both queues, clears every slot valid bit, the entry count,
// the last-sweep time and global_list; no clearing pass is needed.
`include "timed_peer_blocklist_table_unit_defines.svh"
module timed_peer_blocklist_table_unit
    import tpbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request queue side
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output out_item_t   result
);
    logic       global_list_reg, global_list_next;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic       res_push;
    out_item_t  res;
    bk_status_t status;

    out_item_t  oq_reg [2];
    logic       oq_wr_reg, oq_wr_next;
    logic       oq_rd_reg, oq_rd_next;
    logic [1:0] oq_cnt_reg, oq_cnt_next;
    logic       oq_pop;

    // Register port: writes land on the access phase; one register only.
    assign pready = 1'b1;
    assign prdata = {31'd0, global_list_reg};

    always_comb
    begin
        global_list_next = global_list_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            global_list_next = pwdata[0];
        end
    end

    tpbt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .global_list (global_list_reg),
        .push        (push),
        .full        (full),
        .item        (item),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Back end starts a request only when the result queue has a free entry;
    // only one request is in flight, so that entry is still free at the end.
    tpbt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_space (oq_cnt_reg != 2'd2),
        .res_push  (res_push),
        .res       (res),
        .status    (status)
    );

    // Result queue: hold each result until its transfer.
    assign empty  = (oq_cnt_reg == 2'd0);
    assign result = oq_reg[oq_rd_reg];
    assign oq_pop = pop && !empty;

    always_comb
    begin
        oq_wr_next  = res_push ? !oq_wr_reg : oq_wr_reg;
        oq_rd_next  = oq_pop ? !oq_rd_reg : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + 2'(res_push) - 2'(oq_pop);
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_list_reg <= 1'b0;
            oq_wr_reg       <= 1'b0;
            oq_rd_reg       <= 1'b0;
            oq_cnt_reg      <= 2'd0;
        end
        else
        begin
            global_list_reg <= global_list_next;
            oq_wr_reg       <= oq_wr_next;
            oq_rd_reg       <= oq_rd_next;
            oq_cnt_reg      <= oq_cnt_next;
        end
    end

    `TPBT_NEVER(a_oq_overflow, res_push && (oq_cnt_reg == 2'd2) && !oq_pop)
    `TPBT_ASSERT(a_pop_only_idle, cmd_pop |-> !status.busy)
    `TPBT_NEVER(a_count_range, status.overflow)
    `TPBT_ASSERT(a_push_while_busy, res_push |-> status.busy)
endmodule
